// ----- design/bblur_pkg.sv -----
`timescale 1ns / 1ps
package bblur_pkg;

    // Word and field widths
    localparam int WORD_W     = 32;
    localparam int PIX_W      = 24;
    localparam int CHAN_W     = 8;
    localparam int COORD_W    = 10;

    // Configuration port
    localparam int CFG_DATA_W = 11;
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 1'b1;
    localparam int FRAME_WIDTH_RESET  = 800;
    localparam int FRAME_HEIGHT_RESET = 600;

    // Queue between front and back (power of two)
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Neighborhood sum and divide by nine: q = (s * 3641) >> 15, exact for s <= 9*255
    localparam int SUM_W       = 12;
    localparam int RECIP_W     = 12;
    localparam logic [RECIP_W-1:0] RECIP_NINE = 12'd3641;
    localparam int RECIP_SHIFT = 15;
    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

    typedef logic [PIX_W-1:0] rgb_t;

    // One output pixel's 3x3 neighborhood, out-of-frame cells already zeroed.
    // Cell index is column * 3 + row (column left to right, row top to bottom).
    typedef struct packed {
        rgb_t [8:0]         px;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
    } nbhd_t;

endpackage

// ----- design/bblur_front.sv -----
`timescale 1ns / 1ps
module bblur_front
    import bblur_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [WORD_W-1:0]     pixel_word,
    input  logic                  flush,
    input  logic                  cfg_write,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [QPTR_W:0]       q_count,
    output logic                  q_push,
    output nbhd_t                 q_entry
);

    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int XW      = CW + 1;
    localparam int RW      = $clog2(MAX_HEIGHT + 2);
    localparam int CMP_A   = (XW > RW) ? XW : RW;
    localparam int CMP_W   = (CMP_A > CFG_DATA_W) ? CMP_A : CFG_DATA_W;
    localparam int CNT_W   = QPTR_W + 2;
    localparam int W_RESET = (FRAME_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RESET;
    localparam int H_RESET = (FRAME_HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT
                                                               : FRAME_HEIGHT_RESET;

    function automatic logic [CMP_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] val,
                                                   input logic [CMP_W-1:0] limit);
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(val);
        priority if (ext == '0)
            clamp_dim = CMP_W'(1);
        else if (ext > limit)
            clamp_dim = limit;
        else
            clamp_dim = ext;
    endfunction

    // Frame size, stored already clamped
    logic [XW-1:0] w_reg;
    logic [RW-1:0] h_reg;

    // Input position
    logic [CW-1:0] in_column_reg, in_column_next;
    logic [RW-1:0] in_row_reg, in_row_next;

    // Line memory: {upper row, middle row} per column
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] mem_rd_reg;
    logic [2*PIX_W-1:0] byp_data_reg;
    logic               f1_byp_reg;

    // Second front stage
    logic                f1_valid_reg;
    logic                f1_emit_reg;
    logic [CW-1:0]       f1_cx_reg;
    rgb_t                f1_v_reg;
    logic                f1_left_reg, f1_right_reg, f1_top_reg, f1_bottom_reg;
    logic [COORD_W-1:0]  f1_x_reg, f1_y_reg;
    logic                f1_last_reg;

    // 3x3 window, [column][row]
    rgb_t [2:0][2:0] win_reg;

    logic          accept;
    logic [CW-1:0] cx;
    logic [RW-1:0] cy;
    logic [XW-1:0] cx_inc;
    logic          row_end, col_zero, emit, last;
    rgb_t          v_in;
    logic [XW-1:0] ox;
    logic [RW-1:0] oy;
    logic          m_left, m_right, m_top, m_bottom;

    logic [2*PIX_W-1:0] rd_pair, wr_pair;
    rgb_t               top_px, mid_px;
    rgb_t [2:0][2:0]    cols;

    // Hold off the producer while the queue plus the stage in flight could overflow
    assign full   = (CNT_W'(q_count) + CNT_W'(f1_valid_reg)) >= CNT_W'(QUEUE_DEPTH);
    assign accept = push && !full;

    // Classify the incoming word: position, emit decision, border masks
    always_comb
    begin
        cx       = (XW'(in_column_reg) >= w_reg) ? '0 : in_column_reg;
        cy       = in_row_reg;
        cx_inc   = XW'(cx) + XW'(1);
        row_end  = cx_inc >= w_reg;
        col_zero = (cx == '0);
        v_in     = (flush || cy >= h_reg) ? '0 : pixel_word[WORD_W-1 -: PIX_W];
        emit     = (cy >= RW'(2)) || ((cy == RW'(1)) && !col_zero);
        last     = col_zero && (cy == h_reg + RW'(1));
        if (col_zero)
        begin
            ox       = w_reg - XW'(1);
            oy       = cy - RW'(2);
            m_left   = (w_reg == XW'(1));
            m_right  = 1'b1;
            m_top    = (cy == RW'(2));
            m_bottom = (cy >= h_reg + RW'(1));
        end
        else
        begin
            // the output column is left of the incoming one, so its right neighbor is real
            ox       = XW'(cx) - XW'(1);
            oy       = cy - RW'(1);
            m_left   = (cx == CW'(1));
            m_right  = 1'b0;
            m_top    = (cy == RW'(1));
            m_bottom = (cy >= h_reg);
        end
        priority if (last)
        begin
            in_column_next = '0;
            in_row_next    = '0;
        end
        else if (row_end)
        begin
            in_column_next = '0;
            in_row_next    = cy + RW'(1);
        end
        else
        begin
            in_column_next = cx_inc[CW-1:0];
            in_row_next    = cy;
        end
    end

    // Control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg         <= XW'(W_RESET);
            h_reg         <= RW'(H_RESET);
            in_column_reg <= '0;
            in_row_reg    <= '0;
            f1_valid_reg  <= 1'b0;
            f1_emit_reg   <= 1'b0;
            f1_byp_reg    <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= accept;
            if (accept)
            begin
                f1_emit_reg <= emit;
                f1_byp_reg  <= f1_valid_reg && (cx == f1_cx_reg);
            end
            if (cfg_write)
            begin
                unique case (cfg_addr)
                    REG_FRAME_WIDTH:
                        w_reg <= XW'(clamp_dim(cfg_data, CMP_W'(MAX_WIDTH)));
                    REG_FRAME_HEIGHT:
                        h_reg <= RW'(clamp_dim(cfg_data, CMP_W'(MAX_HEIGHT)));
                endcase
                in_column_reg <= '0;
                in_row_reg    <= '0;
            end
            else if (accept)
            begin
                in_column_reg <= in_column_next;
                in_row_reg    <= in_row_next;
            end
        end
    end

    // Capture the accepted word for the second stage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_cx_reg     <= cx;
            f1_v_reg      <= v_in;
            f1_left_reg   <= m_left;
            f1_right_reg  <= m_right;
            f1_top_reg    <= m_top;
            f1_bottom_reg <= m_bottom;
            f1_x_reg      <= COORD_W'(ox);
            f1_y_reg      <= COORD_W'(oy);
            f1_last_reg   <= last;
            byp_data_reg  <= wr_pair;
        end
    end

    // Forward the pair being written when the next word reads the same column
    assign rd_pair = f1_byp_reg ? byp_data_reg : mem_rd_reg;
    assign top_px  = rd_pair[2*PIX_W-1:PIX_W];
    assign mid_px  = rd_pair[PIX_W-1:0];
    assign wr_pair = {mid_px, f1_v_reg};

    // Line memory: read on accept, shift rows down in the cycle after
    always_ff @(posedge clk)
    begin
        if (f1_valid_reg)
            line_mem[f1_cx_reg] <= wr_pair;
        if (accept)
            mem_rd_reg <= line_mem[cx];
    end

    // Advance the window by one column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_reg <= '0;
        else if (f1_valid_reg)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= {f1_v_reg, mid_px, top_px};
        end
    end

    // Build the masked neighborhood for the queue
    always_comb
    begin
        cols[0] = win_reg[1];
        cols[1] = win_reg[2];
        cols[2] = {f1_v_reg, mid_px, top_px};
        for (int c = 0; c < 3; c++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if ((c == 0 && f1_left_reg) || (c == 2 && f1_right_reg) ||
                    (k == 0 && f1_top_reg) || (k == 2 && f1_bottom_reg))
                    q_entry.px[c*3 + k] = '0;
                else
                    q_entry.px[c*3 + k] = cols[c][k];
            end
        end
        q_entry.x    = f1_x_reg;
        q_entry.y    = f1_y_reg;
        q_entry.last = f1_last_reg;
    end

    assign q_push = f1_valid_reg && f1_emit_reg;

endmodule

// ----- design/bblur_queue.sv -----
`timescale 1ns / 1ps
module bblur_queue
    import bblur_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  nbhd_t           wr_data,
    input  logic            rd_en,
    output nbhd_t           rd_data,
    output logic            avail,
    output logic [QPTR_W:0] count
);

    nbhd_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            unique case ({wr_en, rd_en})
                2'b10:   count_reg <= count_reg + (QPTR_W+1)'(1);
                2'b01:   count_reg <= count_reg - (QPTR_W+1)'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    // Store incoming word
    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

    assign rd_data = slot_reg[rd_ptr_reg];
    assign avail   = (count_reg != '0);
    assign count   = count_reg;

endmodule

// ----- design/bblur_back.sv -----
`timescale 1ns / 1ps
module bblur_back
    import bblur_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_avail,
    input  nbhd_t              q_data,
    output logic               q_pop,
    output logic               empty,
    input  logic               pop,
    output logic [WORD_W-1:0]  color_word,
    output logic [COORD_W-1:0] out_x,
    output logic [COORD_W-1:0] out_y,
    output logic               frame_last
);

    localparam int PROD_W = SUM_W + RECIP_W;

    logic                   b0_valid_reg;
    logic [2:0][SUM_W-1:0]  sum_reg;
    logic [COORD_W-1:0]     b0_x_reg, b0_y_reg;
    logic                   b0_last_reg;

    logic                   out_valid_reg;
    logic [WORD_W-1:0]      color_reg;
    logic [COORD_W-1:0]     x_reg, y_reg;
    logic                   last_reg;

    logic                   out_take, b0_take;
    logic [2:0][2:0][SUM_W-1:0] col_sum;
    logic [2:0][SUM_W-1:0]  sum_next;
    logic [2:0][PROD_W-1:0] prod;
    logic [2:0][CHAN_W-1:0] quot;

    assign out_take = !out_valid_reg || pop;
    assign b0_take  = !b0_valid_reg || out_take;
    assign q_pop    = q_avail && b0_take;

    // Sum each channel: per column first, then across columns
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                col_sum[ch][c] = SUM_W'(q_data.px[c*3][ch*CHAN_W +: CHAN_W])
                               + SUM_W'(q_data.px[c*3 + 1][ch*CHAN_W +: CHAN_W])
                               + SUM_W'(q_data.px[c*3 + 2][ch*CHAN_W +: CHAN_W]);
            end
            sum_next[ch] = col_sum[ch][0] + col_sum[ch][1] + col_sum[ch][2];
        end
    end

    // Divide by nine through the reciprocal
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            prod[ch] = PROD_W'(sum_reg[ch]) * PROD_W'(RECIP_NINE);
            quot[ch] = prod[ch][RECIP_SHIFT +: CHAN_W];
        end
    end

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (b0_take)
                b0_valid_reg <= q_pop;
            if (out_take)
                out_valid_reg <= b0_valid_reg;
        end
    end

    // Sum stage and output register payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            sum_reg     <= sum_next;
            b0_x_reg    <= q_data.x;
            b0_y_reg    <= q_data.y;
            b0_last_reg <= q_data.last;
        end
        if (out_take && b0_valid_reg)
        begin
            color_reg <= {quot[2], quot[1], quot[0], ALPHA_OPAQUE};
            x_reg     <= b0_x_reg;
            y_reg     <= b0_y_reg;
            last_reg  <= b0_last_reg;
        end
    end

    assign empty      = !out_valid_reg;
    assign color_word = color_reg;
    assign out_x      = x_reg;
    assign out_y      = y_reg;
    assign frame_last = last_reg;

endmodule

// ----- design/box_blur_3x3_rgb.sv -----
`timescale 1ns / 1ps
// 3x3 box blur over a raster stream of RGBA8888 pixel words.
// Input channel: push/full; a word is taken at a clock edge with push high and
// full low. flush marks a drain word; a frame of W x H pixels is followed by
// W+1 flush words, which push the last row and a pixel out of the window.
// Output channel: empty/pop; the blurred pixel (red,green,blue,0xFF), its
// column, row and frame_last sit on the ports while empty is low and leave at
// an edge with pop high. Pixel (x,y) is produced by the word W+1 positions
// after it, then passes the second front stage, queue, sum and output stages.
// Throughput is one word per clock while full is low; the line memory takes one
// read and one write per word; the back end sums and divides one pixel per clock while popped.
// Configuration: cfg_write with cfg_addr 0 (frame width) or 1 (frame height)
// writes cfg_data, clamped to 1..MAX, at once and restarts the frame; write only while idle.
// Reset: 800 x 600, position at the frame start, window cleared. There is no
// clearing pass: line memory contents are only read for rows above the frame.
// When pop stays low the output holds, a four-entry queue absorbs the words in
// flight, and full rises once it could overflow.
module box_blur_3x3_rgb
    import bblur_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [WORD_W-1:0]     pixel_word,
    input  logic                  flush,
    output logic                  empty,
    input  logic                  pop,
    output logic [WORD_W-1:0]     color_word,
    output logic [COORD_W-1:0]    out_x,
    output logic [COORD_W-1:0]    out_y,
    output logic                  frame_last,
    input  logic                  cfg_write,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic            q_push, q_pop, q_avail;
    nbhd_t           q_wr_data, q_rd_data;
    logic [QPTR_W:0] q_count;

    // Front: position tracking, line memory and window
    bblur_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .pixel_word (pixel_word),
        .flush      (flush),
        .cfg_write  (cfg_write),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .q_count    (q_count),
        .q_push     (q_push),
        .q_entry    (q_wr_data)
    );

    // Queue of neighborhoods between front and back
    bblur_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .avail   (q_avail),
        .count   (q_count)
    );

    // Back: sum, divide, output register
    bblur_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_avail    (q_avail),
        .q_data     (q_rd_data),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .color_word (color_word),
        .out_x      (out_x),
        .out_y      (out_y),
        .frame_last (frame_last)
    );

endmodule
